// ===== rtl/uue_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// uue_pkg: shared types and constants of the uuencode line encoder
// Character codes, the result burst that one data byte produces, and the
// 6-bit to printable character mapping.
// -----------------------------------------------------------------------------
package uue_pkg;

	typedef logic [6:0] char_t;

	localparam int MAX_CHARS = 6;

	localparam char_t CHAR_BACKTICK = 7'h60;
	localparam char_t CHAR_NEWLINE  = 7'h0A;
	localparam char_t CHAR_SPACE    = 7'h20;

	// Register map: word index within the configuration space.
	localparam logic REG_TOTAL_BYTES = 1'b0;
	localparam logic [15:0] TOTAL_BYTES_RESET = 16'd1;

	// Characters of one data byte, oldest in entry 0, with their count.
	typedef struct packed {
		logic [2:0]                 cnt;
		char_t [MAX_CHARS-1:0]      chars;
	} burst_t;

	// A zero value is sent as a backtick, anything else offset into printable range.
	function automatic char_t six_to_char(input logic [5:0] v);
		char_t c;
		c = (v == 6'd0) ? CHAR_BACKTICK : char_t'({1'b0, v} + CHAR_SPACE);
		return c;
	endfunction

endpackage

// ===== rtl/uuencode_line_encoder.sv =====
`timescale 1ns / 1ps
// Data path: an accepted byte's burst is written into the burst buffer, and each
// of its characters then passes through the output register.
// Throughput: one character leaves per cycle while the output is not stalled; a
// byte holds the input until the last of its characters (up to six) moves into the
// output register, and a byte that yields none does not hold it.
// Reset: arst_n clears the encoder state and empties the burst buffer and output register; total_bytes resets to 1.
// -----------------------------------------------------------------------------
// uuencode_line_encoder: streaming uuencode line encoder
// Takes raw data bytes and emits the uuencoded text of one buffer per
// configured byte count: length character, groups of four characters,
// newlines between full lines and after the last group.
// -----------------------------------------------------------------------------
module uuencode_line_encoder #(
	parameter int BYTES_PER_LINE = 45
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input data channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// Encoded character channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  out_char,
	output logic        run_last,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic            ready;
	logic            accept;
	logic [15:0]     total_bytes;
	uue_pkg::burst_t burst;

	// A transaction is taken whenever the burst buffer is empty or is handing
	// its final character to the output register in this cycle. The burst of
	// the new byte is then written straight into the buffer.
	assign in_stall = !ready;
	assign accept   = in_valid && ready;

	uue_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.total_bytes (total_bytes)
	);

	// The encoder works out every character of a byte in one pass and keeps
	// the group, line and buffer counters.
	uue_step #(
		.BYTES_PER_LINE (BYTES_PER_LINE)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.total_bytes (total_bytes),
		.burst       (burst)
	);

	// The serializer parts the input side from the output side: a burst waits
	// in its buffer while the output register holds a stalled character.
	uue_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.burst     (burst),
		.ready     (ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.run_last  (run_last)
	);

endmodule

// ===== rtl/uue_cfg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// uue_cfg: configuration register file
// Holds the buffer byte count behind a simple APB-style slave port.
// -----------------------------------------------------------------------------
module uue_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] total_bytes
);

	logic [15:0] total_bytes_q;
	logic        wr_en;

	assign wr_en  = psel && penable && pwrite && (paddr[2] == uue_pkg::REG_TOTAL_BYTES);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_bytes_q <= uue_pkg::TOTAL_BYTES_RESET;
		end else if (wr_en) begin
			total_bytes_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == uue_pkg::REG_TOTAL_BYTES) begin
			prdata = {16'd0, total_bytes_q};
		end
	end

	assign total_bytes = total_bytes_q;

endmodule

// ===== rtl/uue_step.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// uue_step: per-byte encoder
// Holds the group and line state and turns one data byte into its burst of
// zero to six characters in a single pass.
// -----------------------------------------------------------------------------
module uue_step #(
	parameter int BYTES_PER_LINE = 45
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic [15:0]          total_bytes,
	output uue_pkg::burst_t      burst
);

	logic [1:0]  gp_q;
	logic [7:0]  held_q [2];
	logic [5:0]  lb_q;
	logic [15:0] bc_q;

	logic [15:0] total_eff;
	logic [15:0] bc_n;
	logic [5:0]  lb_n;
	logic        last;
	logic        has_len;
	logic        take;
	logic        line_full;
	logic        len2;
	logic [7:0]  b0, b1, b2;
	uue_pkg::char_t seq [7];

	function automatic uue_pkg::char_t len_char(input logic [15:0] remaining);
		logic [5:0] n;
		n = (remaining < 16'(BYTES_PER_LINE)) ? remaining[5:0] : 6'(BYTES_PER_LINE);
		return uue_pkg::six_to_char(n);
	endfunction

	always_comb begin
		total_eff = (total_bytes == 16'd0) ? 16'd1 : total_bytes;
		bc_n      = bc_q + 16'd1;
		lb_n      = lb_q + 6'd1;
		last      = (bc_n >= total_eff);
		has_len   = (bc_q == 16'd0) && (gp_q == 2'd0);
		take      = (gp_q < 2'd2) && !last;
		line_full = (lb_n >= 6'(BYTES_PER_LINE));
		len2      = !take && !last && line_full;

		case (gp_q)
			2'd0: begin
				b0 = data_byte;
				b1 = 8'd0;
				b2 = 8'd0;
			end
			2'd1: begin
				b0 = held_q[0];
				b1 = data_byte;
				b2 = 8'd0;
			end
			default: begin
				b0 = held_q[0];
				b1 = held_q[1];
				b2 = data_byte;
			end
		endcase

		seq[0] = len_char(total_eff);
		seq[1] = uue_pkg::six_to_char(b0[7:2]);
		seq[2] = uue_pkg::six_to_char({b0[1:0], b1[7:4]});
		seq[3] = uue_pkg::six_to_char({b1[3:0], b2[7:6]});
		seq[4] = uue_pkg::six_to_char(b2[5:0]);
		seq[5] = uue_pkg::CHAR_NEWLINE;
		seq[6] = len_char(total_eff - bc_n);

		for (int i = 0; i < uue_pkg::MAX_CHARS; i++) begin
			burst.chars[i] = has_len ? seq[i] : seq[i+1];
		end
		// The first byte of a buffer adds the length character, a closed group gives
		// four characters, the end of the buffer adds a newline, and a full line with
		// more data behind it adds a newline and a fresh length character.
		burst.cnt = {2'b00, has_len} + (take ? 3'd0 : 3'd4) + {2'b00, last}
			+ {1'b0, len2, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q      <= 2'd0;
			held_q[0] <= 8'd0;
			held_q[1] <= 8'd0;
			lb_q      <= 6'd0;
			bc_q      <= 16'd0;
		end else if (accept) begin
			if (take) begin
				held_q[gp_q[0]] <= data_byte;
				gp_q            <= gp_q + 2'd1;
				bc_q            <= bc_n;
				lb_q            <= lb_n;
			end else begin
				gp_q <= 2'd0;
				if (last) begin
					bc_q      <= 16'd0;
					lb_q      <= 6'd0;
					held_q[0] <= 8'd0;
					held_q[1] <= 8'd0;
				end else begin
					bc_q <= bc_n;
					lb_q <= line_full ? 6'd0 : lb_n;
				end
			end
		end
	end

endmodule

// ===== rtl/uue_serial.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// uue_serial: burst buffer and output register
// Holds one burst and hands its characters to the output one per cycle while the output is not stalled.
// -----------------------------------------------------------------------------
module uue_serial (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  uue_pkg::burst_t      burst,
	output logic                 ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [6:0]           out_char,
	output logic                 run_last
);

	uue_pkg::char_t chars_q [uue_pkg::MAX_CHARS];
	logic [2:0]     rem_q;
	logic           ovalid_q;
	uue_pkg::char_t ochar_q;
	logic           olast_q;
	logic           pop;

	assign pop   = (rem_q != 3'd0) && (!ovalid_q || !out_stall);
	assign ready = (rem_q == 3'd0) || ((rem_q == 3'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			if (load) begin
				rem_q <= burst.cnt;
			end else if (pop) begin
				rem_q <= rem_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ochar_q <= chars_q[0];
			olast_q <= (rem_q == 3'd1);
		end
		if (load) begin
			for (int i = 0; i < uue_pkg::MAX_CHARS; i++) begin
				chars_q[i] <= burst.chars[i];
			end
		end else if (pop) begin
			for (int i = 0; i < uue_pkg::MAX_CHARS - 1; i++) begin
				chars_q[i] <= chars_q[i+1];
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_char  = ochar_q;
	assign run_last  = olast_q;

endmodule

// ===== rtl/uue_port_check.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// uue_port_check: port-level checker
// Watches the output channel of the encoder over time.
// -----------------------------------------------------------------------------
module uue_port_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [6:0] out_char,
	input logic       run_last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_char) && $stable(run_last))
		else $error("stalled output payload changed");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == 7'h0A) || ((out_char >= 7'h20) && (out_char <= 7'h60)))
		else $error("character outside the uuencode alphabet");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("gap inside the characters of one byte");

endmodule

bind uuencode_line_encoder uue_port_check u_port_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.run_last  (run_last)
);

// ===== dv/uuencode_line_encoder_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// uuencode_line_encoder_tb: self-checking testbench of the uuencode line encoder
// Feeds data bytes through the input channel and programs the byte count over
// the configuration port. A behavioral encoder inside the bench predicts every
// character. A monitor compares each accepted character, and its end-of-byte
// flag, in order against those predictions. Both channels idle at random, and
// the character side also holds off for one long stretch.
// -----------------------------------------------------------------------------
module uuencode_line_encoder_tb;

	localparam int LINE_BYTES  = 45;
	localparam int HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 200000;
	// Cycles allowed after the last expected character for a byte that yields
	// nothing to work its way through the encoder.
	localparam int SETTLE_CYCLES = 8;

	// One predicted character and whether it closes the burst of its byte.
	typedef struct {
		uue_pkg::char_t ch;
		logic           fin;
	} enc_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  out_char;
	logic        run_last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Predicted characters, oldest first, and the count of failed checks.
	enc_char_t pending_chars[$];
	int        mismatch_count = 0;

	// Idle rates in percent for the byte sender and the character receiver.
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	// Set by a test to ask the receiver for one long hold-off.
	bit hold_req = 1'b0;

	// Encoder state as the bench sees it; the register starts at its reset value.
	logic [15:0] cfg_total = uue_pkg::TOTAL_BYTES_RESET;
	logic [1:0]  grp_pos = 2'd0;
	logic [7:0]  held0 = 8'h00;
	logic [7:0]  held1 = 8'h00;
	logic [5:0]  line_cnt = 6'd0;
	logic [15:0] consumed = 16'd0;

	uuencode_line_encoder #(
		.BYTES_PER_LINE(LINE_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.run_last (run_last),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// Hard stop in case the encoder wedges or a handshake never completes.
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// A six-bit value maps to printable ASCII, except that zero becomes a backtick.
	function automatic uue_pkg::char_t sextet_to_ascii(input logic [5:0] v);
		return (v == 6'd0) ? uue_pkg::CHAR_BACKTICK
			: uue_pkg::char_t'(v) + uue_pkg::CHAR_SPACE;
	endfunction

	// The length character states how many bytes the line carries.
	function automatic uue_pkg::char_t line_len_ascii(input int unsigned remaining);
		return sextet_to_ascii(6'((remaining < LINE_BYTES) ? remaining : LINE_BYTES));
	endfunction

	// Advance the bench's copy of the encoder by one byte and queue the
	// characters it should produce.
	function automatic void encode_byte(input logic [7:0] b);
		int unsigned    tot;
		logic           last;
		logic [7:0]     b0, b1, b2;
		uue_pkg::char_t burst[$];
		enc_char_t      e;

		// A total of zero behaves as a one-byte buffer.
		tot = (cfg_total == 16'd0) ? 1 : cfg_total;
		if (consumed == 16'd0 && grp_pos == 2'd0)
			burst.push_back(line_len_ascii(tot));
		consumed = consumed + 16'd1;
		line_cnt = line_cnt + 6'd1;
		// The buffer ends once the count reaches or passes the total, which
		// matters when the total drops in the middle of a buffer.
		last = (consumed >= tot);

		if (grp_pos < 2'd2 && !last) begin
			if (grp_pos == 2'd0)
				held0 = b;
			else
				held1 = b;
			grp_pos = grp_pos + 2'd1;
		end else begin
			// A short final group is padded with zero bytes.
			case (grp_pos)
				2'd0: begin
					b0 = b;
					b1 = 8'h00;
					b2 = 8'h00;
				end
				2'd1: begin
					b0 = held0;
					b1 = b;
					b2 = 8'h00;
				end
				default: begin
					b0 = held0;
					b1 = held1;
					b2 = b;
				end
			endcase
			burst.push_back(sextet_to_ascii(b0[7:2]));
			burst.push_back(sextet_to_ascii({b0[1:0], b1[7:4]}));
			burst.push_back(sextet_to_ascii({b1[3:0], b2[7:6]}));
			burst.push_back(sextet_to_ascii(b2[5:0]));
			grp_pos = 2'd0;
			if (last) begin
				// The buffer is complete: everything returns to its initial state.
				burst.push_back(uue_pkg::CHAR_NEWLINE);
				consumed = 16'd0;
				line_cnt = 6'd0;
				held0 = 8'h00;
				held1 = 8'h00;
			end else if (line_cnt >= LINE_BYTES) begin
				// A full line with more data behind it opens a new line.
				burst.push_back(uue_pkg::CHAR_NEWLINE);
				burst.push_back(line_len_ascii(tot - consumed));
				line_cnt = 6'd0;
			end
		end

		foreach (burst[k]) begin
			e.ch  = burst[k];
			e.fin = (k == burst.size() - 1);
			pending_chars.push_back(e);
		end
	endfunction

	// Offer one byte, possibly after a random gap, and wait until it is taken.
	// The valid stays high on return so that the next byte can follow at once;
	// anything that lets time pass without sending lowers it first.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		encode_byte(b);
	endtask

	// Stop sending and wait until every predicted character has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Program the byte count once the encoder is quiet. The write lands at the
	// edge of the access cycle, since pready is always high.
	task automatic set_total(input logic [15:0] v);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * uue_pkg::REG_TOTAL_BYTES);
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_total = v;
	endtask

	// Character receiver: random stalls, or one long hold-off on request,
	// counted here so the sender keeps offering bytes meanwhile.
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req) begin
			out_stall <= 1'b1;
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Every accepted character is checked against the oldest prediction.
	always @(posedge clk) begin
		enc_char_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character %h with run_last %b", out_char, run_last);
				mismatch_count++;
			end else begin
				e = pending_chars.pop_front();
				if (out_char !== e.ch) begin
					$error("out_char mismatch: expected %h, got %h", e.ch, out_char);
					mismatch_count++;
				end
				if (run_last !== e.fin) begin
					$error("run_last mismatch: expected %b, got %b", e.fin, run_last);
					mismatch_count++;
				end
			end
		end
	end

	// Out of reset the total is one, so every byte is a buffer of its own.
	task automatic test_reset_total();
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Full groups and final groups of one and two bytes, with extreme bytes.
	task automatic test_group_tails();
		set_total(16'd4);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h01);
		set_total(16'd5);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hAA);
		send_byte(8'h55);
		set_total(16'd2);
		send_byte(8'hFE);
		send_byte(8'h7F);
	endtask

	// A zero total acts like a total of one.
	task automatic test_zero_total();
		set_total(16'd0);
		send_byte(8'h3C);
	endtask

	// Start a buffer at the largest total, then cut it short by lowering the
	// total mid buffer: the next byte closes it at once.
	task automatic test_total_change_midbuffer();
		set_total(16'hFFFF);
		repeat (5) send_byte(8'($urandom));
		set_total(16'd3);
		send_byte(8'($urandom));
	endtask

	// Hold the receiver off for a long stretch while bytes keep coming, so the
	// encoder fills up and stalls its input.
	task automatic test_backpressure();
		set_total(16'd40);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (40) send_byte(8'($urandom));
	endtask

	// Whole buffers of random length and content; some are cut short so the
	// next total takes over in the middle of a buffer.
	task automatic test_random_buffers(input int n_items, input int snd_pct, input int rcv_pct);
		int          sent;
		int          sel;
		int unsigned t;
		int unsigned cnt;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_items) begin
			sel = $urandom_range(99);
			if (sel < 65)
				t = $urandom_range(20, 1);
			else if (sel < 88)
				t = $urandom_range(100, 40);
			else begin
				case ($urandom_range(4))
					0: t = 0;
					1: t = 1;
					2: t = LINE_BYTES;
					3: t = LINE_BYTES + 1;
					default: t = 2 * LINE_BYTES;
				endcase
			end
			set_total(16'(t));
			cnt = (t == 0) ? 1 : t;
			if ($urandom_range(99) < 15)
				cnt = $urandom_range(cnt, 1);
			// The last buffer of a run is cut to the number of bytes left.
			if (cnt > int'(n_items - sent))
				cnt = n_items - sent;
			repeat (cnt) send_byte(8'($urandom));
			sent += cnt;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_total();
		test_group_tails();
		test_zero_total();
		test_total_change_midbuffer();
		test_random_buffers(40, 32, 82);
		test_random_buffers(40, 82, 32);
		test_random_buffers(40, 0, 0);
		test_backpressure();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
